>>> hdl/sha256_byte_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Shared assertion wrappers, clocked on clk; the first form is held off
// during rst, the second also checks the reset behaviour itself.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBH_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBH_ASSERT(label, prop, msg)
`define SBH_ASSERT_NORST(label, prop, msg)
`endif

`endif

>>> hdl/sha_bsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, the round constant table and the initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_bsh_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Sixteen big-endian 32-bit words; word i holds message bytes 4i to 4i+3.
  typedef logic [15:0][31:0] block_t;

  typedef logic [7:0][31:0] hash_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DATA_LAST = 2'd1,
    KIND_EMPTY_LAST = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic start;
    logic clear;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_status_t;

  localparam logic [31:0] INITIAL_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

>>> hdl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream with standard SHA-256 and returns the 256-bit digest
// once the final item of a message has been taken.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] message byte, tuser[0] byte present,
//                        tlast final item of the message
//   m_axis    out        tdata: four 64-bit big-endian digest words
//
// One byte is taken a cycle while a block is being collected. A full block
// runs through the compression core (64 rounds and a fold), while the bytes
// of the next block collect behind it, so the input stalls only briefly at
// each block boundary. The final item adds one or two padding blocks before
// the digest appears. A four-item queue separates input acceptance from
// block handling, and the digest stays in the output register until it is
// taken. Reset is synchronous; no store needs a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher #(
  parameter int QUEUE_DEPTH = sha_bsh_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] byte_present
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // [63:0] digest_0, [127:64] digest_1,
                                       // [191:128] digest_2, [255:192] digest_3
);

  logic                      q_valid;
  logic                      q_pop;
  sha_bsh_pkg::queue_entry_t q_entry;
  sha_bsh_pkg::core_ctl_t    core_ctl;
  sha_bsh_pkg::core_status_t core_stat;
  sha_bsh_pkg::block_t       core_block;
  sha_bsh_pkg::hash_t        core_hash;

  // The front end drops items that carry neither a byte nor the end mark.
  sha_bsh_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_present(s_axis_tuser[0]),
    .in_last   (s_axis_tlast),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // The back end owns the byte count, the block buffer and the padding.
  sha_bsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .core_ctl  (core_ctl),
    .core_block(core_block),
    .core_stat (core_stat),
    .core_hash (core_hash),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // The core keeps the chaining hash and restores the initial values when
  // the back end has taken the digest.
  sha_bsh_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (core_ctl),
    .block (core_block),
    .status(core_stat),
    .hash  (core_hash)
  );

endmodule

`default_nettype wire

>>> hdl/sha_bsh_front.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_byte_stream_hasher_assert.svh"

module sha_bsh_front #(
  parameter int DEPTH = sha_bsh_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data,
  input  logic                      in_present,
  input  logic                      in_last,
  output logic                      q_valid,
  output sha_bsh_pkg::queue_entry_t q_entry,
  input  logic                      q_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sha_bsh_pkg::queue_entry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          keep;
  logic          push;
  logic          pop;
  sha_bsh_pkg::kind_t kind;

  // A non-final item without a byte carries nothing and is dropped here.
  always_comb begin
    keep = 1'b1;
    kind = sha_bsh_pkg::KIND_DATA;
    unique case ({in_last, in_present})
      2'b11: kind = sha_bsh_pkg::KIND_DATA_LAST;
      2'b10: kind = sha_bsh_pkg::KIND_EMPTY_LAST;
      2'b01: kind = sha_bsh_pkg::KIND_DATA;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (fill != CW'(DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && (fill != '0);
  assign q_valid  = (fill != '0);
  assign q_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: kind, data: in_data};
    end
  end

  `SBH_ASSERT(a_front_fill_drops, (pop && !push) |=> (fill == $past(fill) - 1'b1), "queue fill count did not drop on a pop")

endmodule

`default_nettype wire

>>> hdl/sha_bsh_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds, one a cycle, with a rolling schedule, then folds the
// working words into the chaining hash.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_byte_stream_hasher_assert.svh"

module sha_bsh_core (
  input  logic                      clk,
  input  logic                      rst,
  input  sha_bsh_pkg::core_ctl_t    ctl,
  input  sha_bsh_pkg::block_t       block,
  output sha_bsh_pkg::core_status_t status,
  output sha_bsh_pkg::hash_t        hash
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FINAL = 3'b100
  } core_state_t;

  core_state_t         state;
  logic [5:0]          round;
  sha_bsh_pkg::hash_t  wk;
  sha_bsh_pkg::block_t win;
  logic [31:0]         t1;
  logic [31:0]         t2;
  logic [31:0]         w_new;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // win[0] is the schedule word of the current round; the word sixteen
  // rounds ahead is formed at the same time and shifted in at the top.
  always_comb begin
    t1 = wk[7]
       + (ror32(wk[4], 6) ^ ror32(wk[4], 11) ^ ror32(wk[4], 25))
       + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6]))
       + sha_bsh_pkg::ROUND_K[round]
       + win[0];
    t2 = (ror32(wk[0], 2) ^ ror32(wk[0], 13) ^ ror32(wk[0], 22))
       + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
    w_new = (ror32(win[14], 17) ^ ror32(win[14], 19) ^ (win[14] >> 10))
          + win[9]
          + (ror32(win[1], 7) ^ ror32(win[1], 18) ^ (win[1] >> 3))
          + win[0];
  end

  assign status.busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      wk    <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha_bsh_pkg::INITIAL_HASH[i];
      end
    end else begin
      unique case (state)
        C_IDLE: begin
          if (ctl.clear) begin
            for (int i = 0; i < 8; i++) begin
              hash[i] <= sha_bsh_pkg::INITIAL_HASH[i];
            end
          end
          if (ctl.start) begin
            wk    <= hash;
            win   <= block;
            round <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          wk[7] <= wk[6];
          wk[6] <= wk[5];
          wk[5] <= wk[4];
          wk[4] <= wk[3] + t1;
          wk[3] <= wk[2];
          wk[2] <= wk[1];
          wk[1] <= wk[0];
          wk[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_new;
          round   <= round + 1'b1;
          if (round == 6'd63) begin
            state <= C_FINAL;
          end
        end
        C_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + wk[i];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  `SBH_ASSERT(a_core_start_idle, ctl.start |-> (state == C_IDLE), "block started while core busy")
  `SBH_ASSERT(a_core_round_end, (state == C_ROUND && round == 6'd63) |=> (state == C_FINAL), "rounds did not end in the fold step")
  `SBH_ASSERT_NORST(a_core_reset, rst |=> (state == C_IDLE && round == '0), "core not idle after reset")

endmodule

`default_nettype wire

>>> hdl/sha_bsh_back.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher back end
// Packs queued bytes into blocks, builds the padding blocks, drives the
// compression core and holds the digest in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_byte_stream_hasher_assert.svh"

module sha_bsh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  sha_bsh_pkg::queue_entry_t q_entry,
  output logic                      q_pop,
  output sha_bsh_pkg::core_ctl_t    core_ctl,
  output sha_bsh_pkg::block_t       core_block,
  input  sha_bsh_pkg::core_status_t core_stat,
  input  sha_bsh_pkg::hash_t        core_hash,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [255:0]              out_data
);

  typedef enum logic [3:0] {
    B_COLLECT   = 4'b0001,
    B_PAD_MAIN  = 4'b0010,
    B_PAD_EXTRA = 4'b0100,
    B_DRAIN     = 4'b1000
  } back_state_t;

  back_state_t         state;
  back_state_t         state_next;
  logic [60:0]         byte_count;
  sha_bsh_pkg::block_t buf_words;
  sha_bsh_pkg::block_t merged;
  logic [5:0]          pos;
  logic [63:0]         bit_len;
  logic                has_byte;
  logic                is_last;
  logic                block_full;
  logic                core_free;
  logic                out_free;
  logic                digest_load;

  // Bytes below pos come from src when use_src is set, the rest are zero;
  // put_mark places the 0x80 marker at pos, with_len fills the last two
  // words with the message bit length.
  function automatic sha_bsh_pkg::block_t pad_block(
    input sha_bsh_pkg::block_t src,
    input logic [5:0]          p,
    input logic                use_src,
    input logic                put_mark,
    input logic                with_len,
    input logic [63:0]         len
  );
    sha_bsh_pkg::block_t blk;
    blk = src;
    for (int i = 0; i < 16; i++) begin
      for (int l = 0; l < 4; l++) begin
        if (!use_src || (i * 4 + l) >= int'(p)) begin
          blk[i][8*(3-l) +: 8] = 8'h00;
        end
        if (put_mark && (i * 4 + l) == int'(p)) begin
          blk[i][8*(3-l) +: 8] = sha_bsh_pkg::PAD_MARK;
        end
      end
    end
    if (with_len) begin
      blk[14] = len[63:32];
      blk[15] = len[31:0];
    end
    return blk;
  endfunction

  assign pos        = byte_count[5:0];
  assign bit_len    = {byte_count, 3'b000};
  assign has_byte   = (q_entry.kind != sha_bsh_pkg::KIND_EMPTY_LAST);
  assign is_last    = (q_entry.kind != sha_bsh_pkg::KIND_DATA);
  assign block_full = has_byte && (pos == 6'd63);
  assign core_free  = !core_stat.busy;
  assign out_free   = !out_valid || out_ready;

  // The byte that completes a block goes straight into the core's block.
  always_comb begin
    merged = buf_words;
    merged[15][7:0] = q_entry.data;
  end

  always_comb begin
    q_pop       = 1'b0;
    core_ctl    = '0;
    core_block  = merged;
    digest_load = 1'b0;
    state_next  = state;
    unique case (state)
      B_COLLECT: begin
        if (q_valid && (!block_full || core_free)) begin
          q_pop = 1'b1;
          core_ctl.start = block_full;
          if (is_last) begin
            state_next = B_PAD_MAIN;
          end
        end
      end
      B_PAD_MAIN: begin
        core_block = pad_block(buf_words, pos, 1'b1, 1'b1, (pos < 6'd56), bit_len);
        if (core_free) begin
          core_ctl.start = 1'b1;
          state_next = (pos < 6'd56) ? B_DRAIN : B_PAD_EXTRA;
        end
      end
      B_PAD_EXTRA: begin
        core_block = pad_block(buf_words, pos, 1'b0, 1'b0, 1'b1, bit_len);
        if (core_free) begin
          core_ctl.start = 1'b1;
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (core_free && out_free) begin
          digest_load    = 1'b1;
          core_ctl.clear = 1'b1;
          state_next     = B_COLLECT;
        end
      end
      default: state_next = B_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_COLLECT;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && has_byte) begin
        byte_count <= byte_count + 1'b1;
      end
      if (digest_load) begin
        byte_count <= '0;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_byte) begin
      buf_words[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= q_entry.data;
    end
    if (digest_load) begin
      for (int k = 0; k < 4; k++) begin
        out_data[64*k +: 64] <= {core_hash[2*k], core_hash[2*k+1]};
      end
    end
  end

  `SBH_ASSERT(a_back_digest_idle, digest_load |-> (core_free && !core_ctl.start && !q_pop), "digest taken while a block is in flight")

endmodule

`default_nettype wire

>>> verif/sha256_byte_stream_hasher_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher checker
// Watches both stream channels, predicts the digest of every message from
// the bytes taken at the input and compares each digest item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] byte_present
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [255:0] m_axis_tdata,   // [63:0] digest_0, [127:64] digest_1,
                                       // [191:128] digest_2, [255:192] digest_3
  output int           mismatches,
  output int           digests_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LINES = 40;

  localparam logic [7:0] MARK_BYTE = 8'h80;

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Word k holds digest_k.
  typedef logic [3:0][63:0] digest_words_t;

  logic [31:0]   chain_words [8];
  logic [7:0]    block_bytes [64];
  logic [60:0]   byte_total;
  digest_words_t expected_digests [$];
  int            mismatch_count = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic report(input string what);
    if (mismatch_count < REPORT_LINES) begin
      $display("%0t ns: digest mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  task automatic restart_message();
    for (int j = 0; j < 8; j++) begin
      chain_words[j] = START_CHAIN[j];
    end
    byte_total = '0;
  endtask

  // Runs the 64 rounds over block_bytes and folds the result into the chain.
  task automatic fold_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ep, ap;
    int t;
    for (t = 0; t < 16; t++) begin
      sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (t = 0; t < 8; t++) begin
      v[t] = chain_words[t];
    end
    for (t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s0 = rotr(sched[(t+1)%16], 7) ^ rotr(sched[(t+1)%16], 18) ^ (sched[(t+1)%16] >> 3);
        s1 = rotr(sched[(t+14)%16], 17) ^ rotr(sched[(t+14)%16], 19) ^
             (sched[(t+14)%16] >> 10);
        sched[t%16] = sched[t%16] + s0 + sched[(t+9)%16] + s1;
      end
      ep = v[4];
      ap = v[0];
      t1 = v[7] + (rotr(ep, 6) ^ rotr(ep, 11) ^ rotr(ep, 25)) +
           ((ep & v[5]) ^ (~ep & v[6])) + ROUND_CONST[t] + sched[t%16];
      t2 = (rotr(ap, 2) ^ rotr(ap, 13) ^ rotr(ap, 22)) +
           ((ap & v[1]) ^ (ap & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) begin
      chain_words[t] = chain_words[t] + v[t];
    end
  endtask

  always @(posedge clk) begin
    int            pos;
    logic [63:0]   bit_len;
    digest_words_t want;
    if (rst) begin
      restart_message();
      for (int j = 0; j < 64; j++) begin
        block_bytes[j] = '0;
      end
      expected_digests.delete();
    end else begin
      // The output side is checked first: a digest can never belong to an
      // item taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digests.size() == 0) begin
          report($sformatf("digest %h with none expected", m_axis_tdata));
        end else begin
          want = expected_digests.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_axis_tdata[64*k +: 64] !== want[k]) begin
              report($sformatf("digest_%0d got %h, expected %h", k,
                               m_axis_tdata[64*k +: 64], want[k]));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) begin
          block_bytes[byte_total[5:0]] = s_axis_tdata;
          byte_total = byte_total + 61'd1;
          if (byte_total[5:0] == 6'd0) begin
            fold_block();
          end
        end
        if (s_axis_tlast) begin
          pos = int'(byte_total[5:0]);
          block_bytes[pos] = MARK_BYTE;
          for (int j = pos + 1; j < 64; j++) begin
            block_bytes[j] = '0;
          end
          // No room left for the length: close this block and start another.
          if (pos >= 56) begin
            fold_block();
            for (int j = 0; j < 64; j++) begin
              block_bytes[j] = '0;
            end
          end
          bit_len = {byte_total, 3'b000};
          for (int k = 0; k < 8; k++) begin
            block_bytes[56 + k] = bit_len[63 - 8*k -: 8];
          end
          fold_block();
          for (int k = 0; k < 4; k++) begin
            want[k] = {chain_words[2*k], chain_words[2*k + 1]};
          end
          expected_digests = {expected_digests, want};
          restart_message();
        end
      end
    end
    mismatches      <= mismatch_count;
    digests_pending <= expected_digests.size();
  end

endmodule

`default_nettype wire

>>> verif/sha256_byte_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams directed and random messages into the hasher with random gaps and
// back-pressure; a checker beside the block predicts and compares digests.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Bounds of the run. The watchdog limit is several times the longest quiet
  // stretch a correct run can show, which is the long receiver hold-off plus
  // the two padding blocks of the last message.
  localparam int RANDOM_ITEMS    = 640;
  localparam int RANDOM_MESSAGES = 10;
  localparam int LONG_HOLD       = 3000;
  localparam int BURST_MESSAGES  = 20;
  localparam int TAIL_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic [0:0]   s_axis_tuser = '0;   // [0] byte_present
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // [63:0] digest_0 ... [255:192] digest_3

  int mismatches;
  int digests_pending;

  // Book-keeping shared by the sender, the receiver and the watchdog.
  int items_sent    = 0;
  int messages_sent = 0;
  int stall_asks    = 0;
  bit calm          = 1'b0;   // while set, neither side takes a random gap
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sha256_byte_stream_hasher_checker digest_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .digests_pending (digests_pending)
  );

  // Gap lengths for both sides: half of them none, most of the rest short
  // and an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Message lengths gather round the padding boundaries: 55 and 56 bytes
  // decide whether the length fits, 63 and 64 fill a block exactly, and a
  // few messages run over two blocks or more.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return $urandom_range(0, 8);
    end else if (r < 65) begin
      return $urandom_range(52, 60);
    end else if (r < 82) begin
      return $urandom_range(61, 68);
    end else if (r < 92) begin
      return $urandom_range(118, 130);
    end
    return $urandom_range(0, 260);
  endfunction

  // Offers one item after a random gap and returns once it has been taken.
  // When there is no gap the new item follows the last one without tvalid
  // dropping in between.
  task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Sends a whole message of random bytes. Now and then an item without a
  // byte and without tlast is slipped in; the block must ignore it. The
  // message ends either on its last byte or on an empty item with tlast.
  task automatic send_message(input int len, input bit empty_last);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_last);
    end
    if (len == 0 || empty_last) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    messages_sent++;
  endtask

  // The sender holds back until every digest owed has been taken. The
  // checker's count is registered, so it is read only after the next edge.
  task automatic wait_for_digests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);
  endtask

  // Receiver: ready for short runs, then idle for a random gap. When the
  // sender asks for it, it holds tready low for a long stretch so that the
  // output register and the input queue fill and the input stalls.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (stall_asks != 0) begin
        stall_asks = 0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: counts edges at which neither channel moves an item.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("sha256_byte_stream_hasher_tb NOT OK");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The empty message comes first, straight after reset,
    // with an ignored item before it.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // Single-byte messages at both extremes of the byte, each ending on the
    // byte itself.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // "abc", ending on its last byte, with an ignored item in the middle.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // "abc" again, this time closed by an empty last item.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // Two empty messages back to back.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);

    // The sender pauses until every digest so far has come out.
    wait_for_digests();

    // Long receiver hold-off while a burst of short messages keeps coming.
    stall_asks = 1;
    calm = 1'b1;
    repeat (BURST_MESSAGES) send_message(int'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
    calm = 1'b0;

    // Random part: whole messages of random content and length, with
    // stretches where neither side idles and one more pause half-way.
    items_sent    = 0;
    messages_sent = 0;
    while (items_sent < RANDOM_ITEMS || messages_sent < RANDOM_MESSAGES) begin
      calm = ($urandom_range(0, 7) == 0);
      send_message(pick_length(), ($urandom_range(0, 3) == 0));
      if (messages_sent == RANDOM_MESSAGES / 2) begin
        wait_for_digests();
      end
    end
    calm = 1'b0;

    // Drain: wait for the last digests, then let the block settle.
    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && digests_pending == 0) begin
      $display("sha256_byte_stream_hasher_tb OK");
    end else begin
      $display("sha256_byte_stream_hasher_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
